FILE: src/hexrnd_pkg.sv
`timescale 1ns / 1ps
// Package for the pixel-to-hex cube rounding block.
// Holds widths, register codes, reset values and payload types; no dependencies.
package hexrnd_pkg;

    localparam int COORD_BITS = 8;
    localparam int FRAC_BITS  = 38;

    localparam int POINT_W = 24;
    localparam int REL_W   = POINT_W + 1;
    localparam int COEF_W  = 16;
    localparam int INV_W   = 16;
    localparam int PROD_W  = REL_W + COEF_W;
    localparam int SUM_W   = PROD_W + 1;
    localparam int SPLIT_W = 21;
    localparam int HI_W    = SUM_W - SPLIT_W;
    localparam int PLO_W   = SPLIT_W + INV_W;
    localparam int PHI_W   = HI_W + INV_W + 1;
    localparam int FIX_W   = SUM_W + INV_W + 1;
    localparam int ERR_W   = FRAC_BITS;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_SIZE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_A   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_B   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_C   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_D   = 3'd6;

    typedef struct packed {
        logic signed [POINT_W-1:0] point_x;
        logic signed [POINT_W-1:0] point_y;
    } point_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] cube_q;
        logic signed [COORD_BITS-1:0] cube_r;
        logic signed [COORD_BITS-1:0] cube_s;
    } cube_t;

    typedef struct packed {
        logic signed [POINT_W-1:0] origin_x;
        logic signed [POINT_W-1:0] origin_y;
        logic        [INV_W-1:0]   inv_cell_size;
        logic signed [COEF_W-1:0]  coef_a;
        logic signed [COEF_W-1:0]  coef_b;
        logic signed [COEF_W-1:0]  coef_c;
        logic signed [COEF_W-1:0]  coef_d;
    } cfg_t;

    typedef struct packed {
        logic signed [FIX_W-1:0] q;
        logic signed [FIX_W-1:0] r;
        logic signed [FIX_W-1:0] s;
    } fix_t;

    localparam cfg_t CFG_RESET = '{
        origin_x:      24'sd0,
        origin_y:      24'sd0,
        inv_cell_size: 16'd2048,
        coef_a:        16'sd9459,
        coef_b:        -16'sd5461,
        coef_c:        16'sd0,
        coef_d:        16'sd10923
    };

endpackage

FILE: src/hexrnd_cfg.sv
`timescale 1ns / 1ps
// Configuration register file: origin, reciprocal cell size, inverse matrix.
// Depends on hexrnd_pkg.
module hexrnd_cfg (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [hexrnd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [hexrnd_pkg::CFG_DATA_W-1:0] cfg_data,
    output hexrnd_pkg::cfg_t                  cfg
);
    import hexrnd_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_ORIGIN_X: cfg_next.origin_x      = cfg_data[POINT_W-1:0];
                CFG_ORIGIN_Y: cfg_next.origin_y      = cfg_data[POINT_W-1:0];
                CFG_INV_SIZE: cfg_next.inv_cell_size = cfg_data[INV_W-1:0];
                CFG_COEF_A:   cfg_next.coef_a        = cfg_data[COEF_W-1:0];
                CFG_COEF_B:   cfg_next.coef_b        = cfg_data[COEF_W-1:0];
                CFG_COEF_C:   cfg_next.coef_c        = cfg_data[COEF_W-1:0];
                CFG_COEF_D:   cfg_next.coef_d        = cfg_data[COEF_W-1:0];
                default:      cfg_next               = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= CFG_RESET;
        else
            cfg_reg <= cfg_next;
    end

endmodule

FILE: src/hexrnd_xform.sv
`timescale 1ns / 1ps
// Six-stage transform pipeline: origin subtract, matrix products, sums,
// split scaling by the reciprocal cell size, recombine, third cube axis.
// Depends on hexrnd_pkg.
module hexrnd_xform (
    input  logic                clk,
    input  logic                rst_n,
    input  hexrnd_pkg::cfg_t    cfg,
    input  logic                in_valid,
    output logic                in_ready,
    input  hexrnd_pkg::point_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output hexrnd_pkg::fix_t    out_data
);
    import hexrnd_pkg::*;

    localparam int NSTG = 6;

    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] vld_next;
    logic [NSTG-1:0] rdy;

    // stage 1
    logic signed [REL_W-1:0]  rel_x_reg, rel_x_next;
    logic signed [REL_W-1:0]  rel_y_reg, rel_y_next;
    // stage 2
    logic signed [PROD_W-1:0] pa_reg, pa_next;
    logic signed [PROD_W-1:0] pb_reg, pb_next;
    logic signed [PROD_W-1:0] pc_reg, pc_next;
    logic signed [PROD_W-1:0] pd_reg, pd_next;
    // stage 3
    logic signed [SUM_W-1:0]  qsum_reg, qsum_next;
    logic signed [SUM_W-1:0]  rsum_reg, rsum_next;
    // stage 4
    logic        [PLO_W-1:0]  q_lo_reg, q_lo_next;
    logic signed [PHI_W-1:0]  q_hi_reg, q_hi_next;
    logic        [PLO_W-1:0]  r_lo_reg, r_lo_next;
    logic signed [PHI_W-1:0]  r_hi_reg, r_hi_next;
    // stage 5
    logic signed [FIX_W-1:0]  qf_reg, qf_next;
    logic signed [FIX_W-1:0]  rf_reg, rf_next;
    // stage 6
    fix_t                     fix_reg, fix_next;

    logic signed [HI_W-1:0]   q_hi_op;
    logic signed [HI_W-1:0]   r_hi_op;
    logic signed [INV_W:0]    inv_s;

    always_comb
    begin
        rdy[NSTG-1] = !vld_reg[NSTG-1] || out_ready;
        for (int k = NSTG - 2; k >= 0; k--)
            rdy[k] = !vld_reg[k] || rdy[k+1];
    end

    always_comb
    begin
        vld_next = vld_reg;
        if (rdy[0])
            vld_next[0] = in_valid;
        for (int k = 1; k < NSTG; k++)
            if (rdy[k])
                vld_next[k] = vld_reg[k-1];
    end

    assign in_ready  = rdy[0];
    assign out_valid = vld_reg[NSTG-1];
    assign out_data  = fix_reg;

    assign q_hi_op = qsum_reg[SUM_W-1:SPLIT_W];
    assign r_hi_op = rsum_reg[SUM_W-1:SPLIT_W];
    assign inv_s   = {1'b0, cfg.inv_cell_size};

    always_comb
    begin
        rel_x_next = REL_W'(in_data.point_x) - REL_W'(cfg.origin_x);
        rel_y_next = REL_W'(in_data.point_y) - REL_W'(cfg.origin_y);

        pa_next = PROD_W'(cfg.coef_a) * PROD_W'(rel_x_reg);
        pb_next = PROD_W'(cfg.coef_b) * PROD_W'(rel_y_reg);
        pc_next = PROD_W'(cfg.coef_c) * PROD_W'(rel_x_reg);
        pd_next = PROD_W'(cfg.coef_d) * PROD_W'(rel_y_reg);

        qsum_next = SUM_W'(pa_reg) + SUM_W'(pb_reg);
        rsum_next = SUM_W'(pc_reg) + SUM_W'(pd_reg);

        q_lo_next = PLO_W'(qsum_reg[SPLIT_W-1:0]) * PLO_W'(cfg.inv_cell_size);
        r_lo_next = PLO_W'(rsum_reg[SPLIT_W-1:0]) * PLO_W'(cfg.inv_cell_size);
        q_hi_next = PHI_W'(q_hi_op) * PHI_W'(inv_s);
        r_hi_next = PHI_W'(r_hi_op) * PHI_W'(inv_s);

        qf_next = (FIX_W'(q_hi_reg) <<< SPLIT_W) + FIX_W'(q_lo_reg);
        rf_next = (FIX_W'(r_hi_reg) <<< SPLIT_W) + FIX_W'(r_lo_reg);

        fix_next.q = qf_reg;
        fix_next.r = rf_reg;
        fix_next.s = -(qf_reg + rf_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            rel_x_reg <= rel_x_next;
            rel_y_reg <= rel_y_next;
        end
        if (rdy[1])
        begin
            pa_reg <= pa_next;
            pb_reg <= pb_next;
            pc_reg <= pc_next;
            pd_reg <= pd_next;
        end
        if (rdy[2])
        begin
            qsum_reg <= qsum_next;
            rsum_reg <= rsum_next;
        end
        if (rdy[3])
        begin
            q_lo_reg <= q_lo_next;
            q_hi_reg <= q_hi_next;
            r_lo_reg <= r_lo_next;
            r_hi_reg <= r_hi_next;
        end
        if (rdy[4])
        begin
            qf_reg <= qf_next;
            rf_reg <= rf_next;
        end
        if (rdy[5])
            fix_reg <= fix_next;
    end

endmodule

FILE: src/hexrnd_round.sv
`timescale 1ns / 1ps
// Two-stage cube rounding: round half away from zero with error magnitudes,
// then rebuild the axis with the largest error from the other two.
// Depends on hexrnd_pkg.
module hexrnd_round (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  hexrnd_pkg::fix_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output hexrnd_pkg::cube_t out_data
);
    import hexrnd_pkg::*;

    typedef struct packed {
        logic [COORD_BITS-1:0] val;
        logic [ERR_W-1:0]      err;
    } rnd_t;

    function automatic rnd_t round_fix(input logic signed [FIX_W-1:0] v);
        logic                  neg;
        logic [FIX_W-1:0]      m;
        logic [FRAC_BITS-1:0]  frac;
        logic                  up;
        logic [COORD_BITS-1:0] n;
        rnd_t                  res;
        neg      = v[FIX_W-1];
        m        = neg ? -v : v;
        frac     = m[FRAC_BITS-1:0];
        up       = frac[FRAC_BITS-1];
        n        = m[FRAC_BITS +: COORD_BITS] + COORD_BITS'(up);
        res.val  = neg ? -n : n;
        res.err  = up ? -frac : frac;
        return res;
    endfunction

    logic [1:0] vld_reg;
    logic [1:0] vld_next;
    logic [1:0] rdy;

    rnd_t  q_rnd_reg, q_rnd_next;
    rnd_t  r_rnd_reg, r_rnd_next;
    rnd_t  s_rnd_reg, s_rnd_next;
    cube_t cube_reg, cube_next;

    assign rdy[1]    = !vld_reg[1] || out_ready;
    assign rdy[0]    = !vld_reg[0] || rdy[1];
    assign in_ready  = rdy[0];
    assign out_valid = vld_reg[1];
    assign out_data  = cube_reg;

    always_comb
    begin
        vld_next = vld_reg;
        if (rdy[0])
            vld_next[0] = in_valid;
        if (rdy[1])
            vld_next[1] = vld_reg[0];
    end

    always_comb
    begin
        q_rnd_next = round_fix(in_data.q);
        r_rnd_next = round_fix(in_data.r);
        s_rnd_next = round_fix(in_data.s);

        cube_next.cube_q = q_rnd_reg.val;
        cube_next.cube_r = r_rnd_reg.val;
        cube_next.cube_s = s_rnd_reg.val;
        priority if (q_rnd_reg.err > r_rnd_reg.err && q_rnd_reg.err > s_rnd_reg.err)
            cube_next.cube_q = -(r_rnd_reg.val + s_rnd_reg.val);
        else if (r_rnd_reg.err > s_rnd_reg.err)
            cube_next.cube_r = -(q_rnd_reg.val + s_rnd_reg.val);
        else
            cube_next.cube_s = -(q_rnd_reg.val + r_rnd_reg.val);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            q_rnd_reg <= q_rnd_next;
            r_rnd_reg <= r_rnd_next;
            s_rnd_reg <= s_rnd_next;
        end
        if (rdy[1])
            cube_reg <= cube_next;
    end

endmodule

FILE: src/pixel_to_hex_cube_round_top.sv
`timescale 1ns / 1ps
// Pixel point to hex cube coordinate converter, top level.
// Depends on hexrnd_pkg, hexrnd_cfg, hexrnd_xform, hexrnd_round.
//
// One pixel point (signed Q16.8) goes in per request and one cube coordinate
// triple (q, r, s, wrapped to 8 bits, q+r+s=0) comes out per request, in order.
// The block takes a new point every cycle while point_stall is low; a point's
// result passes through 8 register stages before it shows on the cube channel:
// origin subtract, 25x16 matrix products, sums, 21x16 and 21x17 partial
// products for the reciprocal-size scaling, recombine, third axis,
// rounding, and the largest-error fixup. A stalled output holds only the full
// stages, so empty stages still take points. Configuration writes are
// always ready and take effect on the next cycle; write them only while no
// point is in flight. Register indexes 0..6: origin_x, origin_y,
// inv_cell_size, coef_a, coef_b, coef_c, coef_d; index 7 is ignored.
module pixel_to_hex_cube_round_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              point_valid,
    output logic                              point_stall,
    input  hexrnd_pkg::point_t                point,
    output logic                              cube_valid,
    input  logic                              cube_stall,
    output hexrnd_pkg::cube_t                 cube,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [hexrnd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [hexrnd_pkg::CFG_DATA_W-1:0] cfg_data
);
    import hexrnd_pkg::*;

    cfg_t cfg;
    fix_t fix;
    logic fix_valid;
    logic fix_ready;
    logic point_ready;

    assign point_stall = !point_ready;

    hexrnd_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    hexrnd_xform u_xform (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (point_valid),
        .in_ready  (point_ready),
        .in_data   (point),
        .out_valid (fix_valid),
        .out_ready (fix_ready),
        .out_data  (fix)
    );

    hexrnd_round u_round (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fix_valid),
        .in_ready  (fix_ready),
        .in_data   (fix),
        .out_valid (cube_valid),
        .out_ready (!cube_stall),
        .out_data  (cube)
    );

endmodule

FILE: src/hexrnd_chk.sv
`timescale 1ns / 1ps
// Port-level checker for the pixel-to-hex cube rounding top, bound in below.
// Depends on hexrnd_pkg.
module hexrnd_chk (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              point_valid,
    input logic                              point_stall,
    input hexrnd_pkg::point_t                point,
    input logic                              cube_valid,
    input logic                              cube_stall,
    input hexrnd_pkg::cube_t                 cube,
    input logic                              cfg_valid,
    input logic                              cfg_ready,
    input logic [hexrnd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input logic [hexrnd_pkg::CFG_DATA_W-1:0] cfg_data
);
    import hexrnd_pkg::*;

    logic [COORD_BITS-1:0] cube_sum;

    assign cube_sum = cube.cube_q + cube.cube_r + cube.cube_s;

    // held result stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        cube_valid && cube_stall |=> cube_valid && $stable(cube))
        else $error("stalled cube result changed");

    // held point request stays put
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        point_valid && point_stall |=> point_valid && $stable(point))
        else $error("stalled point request changed");

    // cube coordinates always sum to zero modulo 2^COORD_BITS
    a_cube_sum: assert property (@(posedge clk) disable iff (!rst_n)
        cube_valid |-> cube_sum == '0)
        else $error("cube q+r+s not zero");

    // input only backs up when the output is held
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        point_stall |-> cube_valid && cube_stall)
        else $error("point stalled with output free");

    // config port never blocks and carries known values
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready && !$isunknown({cfg_index, cfg_data}))
        else $error("config write refused or unknown");

endmodule

bind pixel_to_hex_cube_round_top hexrnd_chk u_chk (.*);
